// ===== rtl/core/md5bsh_pkg.sv =====
// md5 byte stream hasher: shared types, constants and round helper functions
// used by the controller, the datapath and the top level; no dependencies
package md5bsh_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} msg_word_t;

	typedef struct packed {
		logic [7:0] digest_byte;
		logic [3:0] digest_index;
		logic       digest_last;
	} dig_word_t;

	typedef enum logic [1:0] {
		SRC_DATA = 2'd0,
		SRC_PAD  = 2'd1,
		SRC_ZERO = 2'd2
	} byte_src_t;

	typedef struct packed {
		logic      wr_en;
		byte_src_t wr_src;
		logic      cnt_inc;
		logic      wr_len;
		logic      round_en;
		logic      fin;
		logic      chain_rst;
		logic      out_step;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       round_last;
		logic       out_last;
	} dp_stat_t;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'd63;

	localparam logic [31:0] INIT_CHAIN [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [31:0] STEP_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// message word used by round i
	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] lo;
		logic [3:0] r;
		lo = i[3:0];
		case (i[5:4])
			2'd0: r = lo;
			2'd1: r = 4'(lo * 4'd5 + 4'd1);
			2'd2: r = 4'(lo * 4'd3 + 4'd5);
			2'd3: r = 4'(lo * 4'd7);
			default: r = lo;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] w;
		w = {x, x} << s;
		return w[63:32];
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] phase,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (phase)
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (b & d) | (c & ~d);
			2'd2: f = b ^ c ^ d;
			2'd3: f = c ^ (b | ~d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

endpackage

// ===== rtl/core/md5bsh_dpath.sv =====
// md5 byte stream hasher datapath: block buffer, fill and bit counters,
// round unit, chaining words and digest byte select; uses md5bsh_pkg
module md5bsh_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  md5bsh_pkg::dp_cmd_t   cmd,
	input  logic [7:0]            data_byte,
	output md5bsh_pkg::dp_stat_t  stat,
	output md5bsh_pkg::dig_word_t dig_word
);

	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] block_q [16];
	logic [5:0]  fill_q;
	logic [63:0] count_q;
	logic [5:0]  rnd_q;
	logic [3:0]  idx_q;
	logic [31:0] km_q;

	logic [7:0]  wr_byte;
	logic [31:0] f_val;
	logic [31:0] sum_val;
	logic [31:0] t_val;
	logic [5:0]  nidx;

	always_comb begin
		case (cmd.wr_src)
			md5bsh_pkg::SRC_DATA: wr_byte = data_byte;
			md5bsh_pkg::SRC_PAD:  wr_byte = md5bsh_pkg::PAD_BYTE;
			md5bsh_pkg::SRC_ZERO: wr_byte = 8'h00;
			default:              wr_byte = 8'h00;
		endcase
	end

	// one round per cycle, constant plus message word prefetched into km_q
	assign f_val   = md5bsh_pkg::round_f(rnd_q[5:4], b_q, c_q, d_q);
	assign sum_val = a_q + f_val + km_q;
	assign t_val   = b_q + md5bsh_pkg::rotl(sum_val,
		md5bsh_pkg::ROT_S[{rnd_q[5:4], rnd_q[1:0]}]);
	assign nidx    = cmd.round_en ? rnd_q + 6'd1 : rnd_q;

	always_ff @(posedge clk) begin
		km_q <= md5bsh_pkg::STEP_K[nidx] + block_q[md5bsh_pkg::msg_index(nidx)];
		if (cmd.wr_en) begin
			block_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= wr_byte;
		end
		if (cmd.wr_len) begin
			block_q[14] <= count_q[31:0];
			block_q[15] <= count_q[63:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.wr_en) begin
				fill_q <= fill_q + 6'd1;
			end else if (cmd.wr_len) begin
				fill_q <= '0;
			end
			if (cmd.chain_rst) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + 64'd8;
			end
			if (cmd.round_en) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (cmd.out_step) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	// working words mirror the chain outside a compression
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				chain_q[i] <= md5bsh_pkg::INIT_CHAIN[i];
			end
			a_q <= md5bsh_pkg::INIT_CHAIN[0];
			b_q <= md5bsh_pkg::INIT_CHAIN[1];
			c_q <= md5bsh_pkg::INIT_CHAIN[2];
			d_q <= md5bsh_pkg::INIT_CHAIN[3];
		end else if (cmd.chain_rst) begin
			for (int i = 0; i < 4; i++) begin
				chain_q[i] <= md5bsh_pkg::INIT_CHAIN[i];
			end
			a_q <= md5bsh_pkg::INIT_CHAIN[0];
			b_q <= md5bsh_pkg::INIT_CHAIN[1];
			c_q <= md5bsh_pkg::INIT_CHAIN[2];
			d_q <= md5bsh_pkg::INIT_CHAIN[3];
		end else if (cmd.fin) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			a_q <= chain_q[0] + a_q;
			b_q <= chain_q[1] + b_q;
			c_q <= chain_q[2] + c_q;
			d_q <= chain_q[3] + d_q;
		end else if (cmd.round_en) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= t_val;
		end
	end

	assign stat.fill       = fill_q;
	assign stat.round_last = &rnd_q;
	assign stat.out_last   = &idx_q;

	assign dig_word.digest_byte  = chain_q[idx_q[3:2]][{idx_q[1:0], 3'b000} +: 8];
	assign dig_word.digest_index = idx_q;
	assign dig_word.digest_last  = &idx_q;

endmodule

// ===== rtl/core/md5bsh_ctrl.sv =====
// md5 byte stream hasher controller: sequences byte intake, padding,
// compression and digest output; uses md5bsh_pkg
module md5bsh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 msg_valid,
	input  logic                 byte_present,
	input  logic                 end_of_message,
	output logic                 msg_ready,
	output logic                 dig_valid,
	input  logic                 dig_ready,
	input  md5bsh_pkg::dp_stat_t stat,
	output md5bsh_pkg::dp_cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_PAD  = 8'b00000010,
		ST_ZERO = 8'b00000100,
		ST_LEN  = 8'b00001000,
		ST_PREP = 8'b00010000,
		ST_COMP = 8'b00100000,
		ST_FIN  = 8'b01000000,
		ST_OUT  = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic   end_pend_q, end_pend_d;
	logic   pad_done_q, pad_done_d;
	logic   final_q, final_d;
	logic   msg_acc;
	logic   dig_acc;

	assign msg_ready = (state_q == ST_IDLE);
	assign dig_valid = (state_q == ST_OUT);
	assign msg_acc   = msg_valid & msg_ready;
	assign dig_acc   = dig_valid & dig_ready;

	always_comb begin
		state_d    = state_q;
		end_pend_d = end_pend_q;
		pad_done_d = pad_done_q;
		final_d    = final_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (msg_acc) begin
					cmd.wr_en   = byte_present;
					cmd.wr_src  = md5bsh_pkg::SRC_DATA;
					cmd.cnt_inc = byte_present;
					if (byte_present && stat.fill == md5bsh_pkg::FILL_LAST) begin
						end_pend_d = end_of_message;
						state_d    = ST_PREP;
					end else if (end_of_message) begin
						end_pend_d = 1'b1;
						state_d    = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = md5bsh_pkg::SRC_PAD;
				pad_done_d = 1'b1;
				state_d    = (stat.fill == md5bsh_pkg::FILL_LAST) ? ST_PREP : ST_ZERO;
			end
			ST_ZERO: begin
				if (stat.fill == md5bsh_pkg::LEN_POS) begin
					state_d = ST_LEN;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_src = md5bsh_pkg::SRC_ZERO;
					if (stat.fill == md5bsh_pkg::FILL_LAST) begin
						state_d = ST_PREP;
					end
				end
			end
			ST_LEN: begin
				cmd.wr_len = 1'b1;
				final_d    = 1'b1;
				state_d    = ST_PREP;
			end
			ST_PREP: begin
				state_d = ST_COMP;
			end
			ST_COMP: begin
				cmd.round_en = 1'b1;
				if (stat.round_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				if (final_q) begin
					state_d = ST_OUT;
				end else if (end_pend_q && !pad_done_q) begin
					state_d = ST_PAD;
				end else if (end_pend_q) begin
					state_d = ST_ZERO;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (dig_acc) begin
					cmd.out_step = 1'b1;
					if (stat.out_last) begin
						cmd.chain_rst = 1'b1;
						end_pend_d    = 1'b0;
						pad_done_d    = 1'b0;
						final_d       = 1'b0;
						state_d       = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			end_pend_q <= 1'b0;
			pad_done_q <= 1'b0;
			final_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			end_pend_q <= end_pend_d;
			pad_done_q <= pad_done_d;
			final_q    <= final_d;
		end
	end

endmodule

// ===== rtl/core/md5_byte_stream_hasher.sv =====
// md5 byte stream hasher top level: joins controller and datapath
// depends on md5bsh_pkg, md5bsh_ctrl, md5bsh_dpath
//
// usage
//   msg channel (msg_valid / msg_ready / msg_word): one word per message byte,
//   byte_present marks a real byte, end_of_message marks the last word; a word
//   with end set and no byte closes the message as it stands (empty message ok)
//   dig channel (dig_valid / dig_ready / dig_word): 16 digest bytes per
//   message, index 0 to 15, little-endian within each chaining word
// throughput and sequencing
//   bytes go in at one per cycle while a block fills
//   a full 64-byte block holds msg_ready low while it is compressed: a
//   prefetch of the first round operand, 64 rounds on the single round unit,
//   then a fold into the chaining words
//   at message end: a pad byte, zero bytes up to byte 56 and a step that
//   finds the length slot, the length words, then compression; if the pad
//   byte lands past byte 55 a second zero run and compression follow
//   the digest then drains at one byte per cycle while dig_ready is high
// reset: chaining words take the standard initial values, fill and bit
//   count clear; the same happens after the sixteenth digest byte is taken
// stall: a low dig_ready just holds the current digest byte; no new message
//   word is taken until the whole digest has been delivered
module md5_byte_stream_hasher (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	output logic                  msg_ready,
	input  md5bsh_pkg::msg_word_t msg_word,
	output logic                  dig_valid,
	input  logic                  dig_ready,
	output md5bsh_pkg::dig_word_t dig_word
);

	// command and status between controller and datapath
	md5bsh_pkg::dp_cmd_t  cmd;
	md5bsh_pkg::dp_stat_t stat;

	md5bsh_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.byte_present   (msg_word.byte_present),
		.end_of_message (msg_word.end_of_message),
		.msg_ready      (msg_ready),
		.dig_valid      (dig_valid),
		.dig_ready      (dig_ready),
		.stat           (stat),
		.cmd            (cmd)
	);

	md5bsh_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (msg_word.data_byte),
		.stat      (stat),
		.dig_word  (dig_word)
	);

	// intake and digest output never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && dig_valid))
		else $error("message intake open while digest pending");

	// the digest run starts at index zero
	a_dig_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dig_valid) |-> dig_word.digest_index == 4'd0)
		else $error("digest run does not start at byte zero");

	// taking a non-final digest byte moves to the next index
	a_dig_step: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && dig_ready && !dig_word.digest_last) |=>
			(dig_valid && dig_word.digest_index == 4'($past(dig_word.digest_index) + 4'd1)))
		else $error("digest index did not advance");

	// after the last digest byte the block is ready for a new message
	a_dig_end: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && dig_ready && dig_word.digest_last) |=> (msg_ready && !dig_valid))
		else $error("block not idle after last digest byte");

endmodule
